[rtl/adfp_pkg.sv]
// Shared types, constants and conversion tables for the ASCII decimal field parser.
// No dependencies; used by every module of the block.
package adfp_pkg;

  localparam int FRAC_DIGITS = 4;

  localparam int IntW   = 15;
  localparam int FracW  = 14;
  localparam int FdigW  = 3;
  localparam int CountW = 8;
  localparam int ValueW = 32;
  localparam int RecipW = 31;
  localparam int ProdW  = 46;
  localparam int ShiftW = 5;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [IntW-1:0]   IntMax         = 15'h7FFF;
  localparam logic [FdigW-1:0]  FracLimit      = FdigW'(FRAC_DIGITS);
  localparam logic [CountW-1:0] MaxValuesReset = 8'd10;

  // Field captured at its terminating character.
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              last;
    logic              minus;
    logic [IntW-1:0]   int_part;
    logic [FracW-1:0]  frac_acc;
    logic [FdigW-1:0]  frac_digits;
    logic [CountW-1:0] index;
    logic [CountW-1:0] count;
  } adfp_field_t;

  // Field after the reciprocal multiply.
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              last;
    logic              minus;
    logic [IntW-1:0]   int_part;
    logic [ProdW-1:0]  product;
    logic [FdigW-1:0]  frac_digits;
    logic [CountW-1:0] index;
    logic [CountW-1:0] count;
  } adfp_prod_t;

  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        index;
    logic                     has_value;
    logic                     done;
    logic [CountW-1:0]        count;
  } adfp_result_t;

  // frac * 65536 / 10^k, rounded half up, equals (frac * m + 2^(s-1)) >> s
  // with m = ceil(2^(16+s) / 10^k) and 2^s >= 2 * 10^(2k), since frac < 10^k.
  function automatic logic [RecipW-1:0] frac_recip(input logic [FdigW-1:0] k);
    logic [RecipW-1:0] m;
    case (k)
      3'd0:    m = 31'd131072;
      3'd1:    m = 31'd1677722;
      3'd2:    m = 31'd21474837;
      3'd3:    m = 31'd137438954;
      3'd4:    m = 31'd1759218605;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [ShiftW-1:0] frac_shift(input logic [FdigW-1:0] k);
    logic [ShiftW-1:0] s;
    case (k)
      3'd0:    s = 5'd1;
      3'd1:    s = 5'd8;
      3'd2:    s = 5'd15;
      3'd3:    s = 5'd21;
      3'd4:    s = 5'd28;
      default: s = 5'd1;
    endcase
    return s;
  endfunction

endpackage

[rtl/adfp_field_parse.sv]
// Character front end: header, field and line state, and the captured-field register.
// Depends on adfp_pkg.
module adfp_field_parse import adfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              advance_i,
  input  logic [7:0]        character_i,
  input  logic              line_end_i,
  input  logic [CountW-1:0] max_values_i,
  output adfp_field_t       field_o
);

  logic              header_q, header_d;
  logic [IntW-1:0]   int_q, int_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [FdigW-1:0]  fdig_q, fdig_d;
  logic              point_q, point_d;
  logic              minus_q, minus_d;
  logic              nonempty_q, nonempty_d;
  logic [CountW-1:0] count_q, count_d;
  logic              limit_q, limit_d;
  adfp_field_t       field_q, field_d;

  logic              is_digit;
  logic [3:0]        digit;
  logic [18:0]       int_next;
  logic              ends;
  logic              emit;

  assign is_digit = (character_i >= CharZero) && (character_i <= CharNine);
  assign digit    = character_i[3:0];
  assign int_next = 19'(int_q) * 19'd10 + 19'(digit);

  always_comb begin
    header_d   = header_q;
    int_d      = int_q;
    frac_d     = frac_q;
    fdig_d     = fdig_q;
    point_d    = point_q;
    minus_d    = minus_q;
    nonempty_d = nonempty_q;
    count_d    = count_q;
    limit_d    = limit_q;
    ends       = 1'b0;
    emit       = 1'b0;
    field_d    = '0;

    if (!header_q) begin
      if (character_i == CharColon) begin
        header_d = 1'b1;
      end
    end else if (!limit_q) begin
      ends = (character_i == CharSpace) || line_end_i;
      if (character_i == CharMinus) begin
        minus_d    = 1'b1;
        nonempty_d = 1'b1;
      end else if (character_i == CharDot) begin
        point_d    = 1'b1;
        nonempty_d = 1'b1;
      end else if (is_digit) begin
        nonempty_d = 1'b1;
        if (!point_q) begin
          int_d = (int_next > 19'(IntMax)) ? IntMax : int_next[IntW-1:0];
        end else if (fdig_q < FracLimit) begin
          frac_d = frac_q * 14'd10 + FracW'(digit);
          fdig_d = fdig_q + 3'd1;
        end
      end
      if (ends) begin
        if (nonempty_d && (count_q < max_values_i)) begin
          emit    = 1'b1;
          count_d = count_q + 8'd1;
          if (count_d >= max_values_i) begin
            limit_d = 1'b1;
          end
        end
      end
    end

    field_d.valid       = emit || line_end_i;
    field_d.emit        = emit;
    field_d.last        = line_end_i;
    field_d.minus       = minus_d;
    field_d.int_part    = int_d;
    field_d.frac_acc    = frac_d;
    field_d.frac_digits = fdig_d;
    field_d.index       = count_q;
    field_d.count       = count_d;

    // field boundary: back to an empty field
    if (ends) begin
      int_d      = '0;
      frac_d     = '0;
      fdig_d     = '0;
      point_d    = 1'b0;
      minus_d    = 1'b0;
      nonempty_d = 1'b0;
    end
    // line boundary: back to reset
    if (line_end_i) begin
      int_d      = '0;
      frac_d     = '0;
      fdig_d     = '0;
      point_d    = 1'b0;
      minus_d    = 1'b0;
      nonempty_d = 1'b0;
      header_d   = 1'b0;
      count_d    = '0;
      limit_d    = 1'b0;
    end
    if (!accept_i) begin
      field_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= 1'b0;
      int_q      <= '0;
      frac_q     <= '0;
      fdig_q     <= '0;
      point_q    <= 1'b0;
      minus_q    <= 1'b0;
      nonempty_q <= 1'b0;
      count_q    <= '0;
      limit_q    <= 1'b0;
    end else if (accept_i) begin
      header_q   <= header_d;
      int_q      <= int_d;
      frac_q     <= frac_d;
      fdig_q     <= fdig_d;
      point_q    <= point_d;
      minus_q    <= minus_d;
      nonempty_q <= nonempty_d;
      count_q    <= count_d;
      limit_q    <= limit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
    end else if (advance_i) begin
      field_q <= field_d;
    end
  end

  assign field_o = field_q;

endmodule

[rtl/adfp_convert.sv]
// Fixed-point conversion: reciprocal multiply stage, then round, sign and result register.
// Depends on adfp_pkg.
module adfp_convert import adfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  adfp_field_t  field_i,
  output adfp_result_t result_o
);

  adfp_prod_t   prod_q, prod_d;
  adfp_result_t res_q, res_d;

  logic [ProdW-1:0]  rounded;
  logic [ProdW-1:0]  shifted;
  logic [15:0]       frac16;
  logic [ValueW-1:0] mag;
  logic [ShiftW-1:0] shamt;

  always_comb begin
    prod_d.valid       = field_i.valid;
    prod_d.emit        = field_i.emit;
    prod_d.last        = field_i.last;
    prod_d.minus       = field_i.minus;
    prod_d.int_part    = field_i.int_part;
    prod_d.frac_digits = field_i.frac_digits;
    prod_d.index       = field_i.index;
    prod_d.count       = field_i.count;
    prod_d.product     = ProdW'(field_i.frac_acc) * ProdW'(frac_recip(field_i.frac_digits));
  end

  always_comb begin
    shamt   = frac_shift(prod_q.frac_digits);
    rounded = prod_q.product + (ProdW'(1) << (shamt - 5'd1));
    shifted = rounded >> shamt;
    frac16  = (|shifted[ProdW-1:16]) ? 16'hFFFF : shifted[15:0];
    mag     = {1'b0, prod_q.int_part, frac16};

    res_d.valid     = prod_q.valid;
    res_d.has_value = prod_q.emit;
    res_d.done      = prod_q.last;
    res_d.count     = prod_q.count;
    res_d.index     = prod_q.emit ? prod_q.index : '0;
    if (!prod_q.emit) begin
      res_d.value = '0;
    end else if (prod_q.minus) begin
      res_d.value = -$signed(mag);
    end else begin
      res_d.value = $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      res_q  <= '0;
    end else if (advance_i) begin
      prod_q <= prod_d;
      res_q  <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

[rtl/ascii_decimal_field_parser_unit.sv]
// Top level of the ASCII decimal field parser: ports, limit register, pipeline control.
// Depends on adfp_pkg, adfp_field_parse and adfp_convert.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o): one ASCII character per item,
//   line_end_i set on the last character of a line. Text before the first
//   colon is skipped; after it, space separated fields become Q16.16 numbers.
// - Output channel (out_valid_o / out_ready_i): at most one result item per character;
//   a non-empty field below max_values yields a result at its closing space or line
//   end, and the line end always yields a result with done_res_o set and value_count_o.
// - Config channel (cfg_valid_i / cfg_ready_o): writes max_values, always
//   ready; write only while the block is idle. Resets to 10.
// - Throughput: one character per cycle while the receiver does not stall. The result
//   of a character passes the parse register, loaded at the edge that accepts its
//   item, then the multiply register, then the result register.
// - The three stages advance together; when the receiver stalls with a
//   result pending, in_ready_o drops and the whole pipe holds.
// - Reset (rst_ni low, asynchronous) empties the pipe and clears all line
//   and field state.
module ascii_decimal_field_parser_unit import adfp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // character items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               character_i,
  input  logic                     line_end_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [CountW-1:0]        value_index_o,
  output logic                     has_value_o,
  output logic                     done_res_o,
  output logic [CountW-1:0]        value_count_o,
  // limit register write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CountW-1:0]        cfg_data_i
);

  logic [CountW-1:0] max_values_q;
  logic              advance;
  logic              accept;
  adfp_field_t       field;
  adfp_result_t      result;

  // pipe moves whenever the result register is empty or being drained
  assign advance    = !result.valid || out_ready_i;
  assign accept     = in_valid_i && advance;
  assign in_ready_o = advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_values_q <= MaxValuesReset;
    end else if (cfg_valid_i) begin
      max_values_q <= cfg_data_i;
    end
  end

  adfp_field_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .advance_i    (advance),
    .character_i  (character_i),
    .line_end_i   (line_end_i),
    .max_values_i (max_values_q),
    .field_o      (field)
  );

  adfp_convert u_convert (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .field_i   (field),
    .result_o  (result)
  );

  assign out_valid_o   = result.valid;
  assign value_o       = result.value;
  assign value_index_o = result.index;
  assign has_value_o   = result.has_value;
  assign done_res_o    = result.done;
  assign value_count_o = result.count;

endmodule
